// File: design/wrapped_interval_alu_core_defines.svh
// Assertion macros for the wrapped interval ALU core.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef WRAPPED_INTERVAL_ALU_CORE_DEFINES_SVH
`define WRAPPED_INTERVAL_ALU_CORE_DEFINES_SVH

`define WIA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define WIA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/wia_pkg.sv
// Shared types, opcodes and interval helpers for the wrapped interval ALU.
// No dependencies; imported by every module of the core.
package wia_pkg;

    localparam int W = 32;

    localparam logic [W-1:0] VMAX = {W{1'b1}};
    localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_SUB   = 4'd1,
        OP_MUL   = 4'd2,
        OP_UDIV  = 4'd3,
        OP_UREM  = 4'd4,
        OP_SREM  = 4'd5,
        OP_JOIN  = 4'd6,
        OP_MEET  = 4'd7,
        OP_WIDEN = 4'd8
    } t_op;

    typedef struct packed {
        logic [3:0]   opcode;
        logic         a_bottom;
        logic [W-1:0] a_begin;
        logic [W-1:0] a_end;
        logic         b_bottom;
        logic [W-1:0] b_begin;
        logic [W-1:0] b_end;
        logic         no_unsigned_wrap;
        logic         no_signed_wrap;
    } t_in;

    typedef struct packed {
        logic         r_bottom;
        logic [W-1:0] r_begin;
        logic [W-1:0] r_end;
    } t_out;

    typedef struct packed {
        logic [W-1:0] a_lo;
        logic [W-1:0] a_hi;
        logic [W-1:0] b_lo;
        logic [W-1:0] b_hi;
    } t_divin;

    typedef struct packed {
        t_out res;
        logic use_mul;
        logic use_div;
    } t_sc;

    function automatic logic is_neg(input logic [W-1:0] x);
        is_neg = x[W-1];
    endfunction

    function automatic logic slt(input logic [W-1:0] x, input logic [W-1:0] y);
        slt = (x ^ SMIN) < (y ^ SMIN);
    endfunction

    function automatic t_out mk(input logic [W-1:0] lo, input logic [W-1:0] hi);
        t_out r;
        r.r_bottom = 1'b0;
        r.r_begin  = lo;
        r.r_end    = hi;
        mk = r;
    endfunction

    function automatic t_out mk_top();
        mk_top = mk({W{1'b0}}, VMAX);
    endfunction

    function automatic t_out mk_bot();
        t_out r;
        r.r_bottom = 1'b1;
        r.r_begin  = {W{1'b0}};
        r.r_end    = {W{1'b0}};
        mk_bot = r;
    endfunction

    function automatic t_out clean(input t_out x);
        clean = x.r_bottom ? mk_bot() : x;
    endfunction

endpackage

// File: design/wia_scalar.sv
// Three-stage datapath for add, sub, urem, srem, join, meet and widen.
// Depends on wia_pkg; flags mul and udiv items for the later units.
module wia_scalar import wia_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_in  i_item,
    output t_sc  o_sc
);

    logic [W-1:0] a_lo, a_hi, b_lo, b_hi, bx_lo, bx_hi;
    logic         anybot, is_sub, nuw_ok, nsw_ok, ovs, ovt;
    logic [W:0]   sum_lo, sum_hi, wsum;
    logic [W-1:0] w1, w2, ux, uy, mx, my, da, dbw;
    t_out         n_add;

    assign a_lo   = i_item.a_begin;
    assign a_hi   = i_item.a_end;
    assign b_lo   = i_item.b_begin;
    assign b_hi   = i_item.b_end;
    assign anybot = i_item.a_bottom | i_item.b_bottom;
    assign is_sub = (i_item.opcode == OP_SUB);
    assign bx_lo  = is_sub ? ({W{1'b0}} - b_hi) : b_lo;
    assign bx_hi  = is_sub ? ({W{1'b0}} - b_lo) : b_hi;
    assign sum_lo = {1'b0, a_lo} + {1'b0, bx_lo};
    assign sum_hi = {1'b0, a_hi} + {1'b0, bx_hi};
    assign w1     = a_hi - a_lo;
    assign w2     = bx_hi - bx_lo;
    assign wsum   = {1'b0, w1} + {1'b0, w2};
    assign nuw_ok = (i_item.opcode == OP_ADD) & i_item.no_unsigned_wrap
                    & (a_lo <= a_hi) & (bx_lo <= bx_hi);
    assign nsw_ok = (i_item.opcode == OP_ADD) & i_item.no_signed_wrap
                    & !slt(a_hi, a_lo) & !slt(bx_hi, bx_lo);
    assign ovs    = is_neg((a_lo ^ sum_lo[W-1:0]) & (bx_lo ^ sum_lo[W-1:0]));
    assign ovt    = is_neg((a_hi ^ sum_hi[W-1:0]) & (bx_hi ^ sum_hi[W-1:0]));

    always_comb begin
        n_add = mk(sum_lo[W-1:0], sum_hi[W-1:0]);
        if (anybot) begin
            n_add = mk_bot();
        end else if (nuw_ok) begin
            if (sum_lo[W]) begin
                n_add = mk_bot();
            end else if (sum_hi[W]) begin
                n_add.r_end = VMAX;
            end
        end else if (nsw_ok) begin
            if (ovs && !is_neg(a_lo)) begin
                n_add = mk_bot();
            end else if (ovt && is_neg(a_hi)) begin
                n_add = mk_bot();
            end else begin
                if (ovs) n_add.r_begin = SMIN;
                if (ovt) n_add.r_end = SMAX;
            end
        end else if (wsum[W]) begin
            n_add = mk_top();
        end
    end

    assign ux  = (a_lo > a_hi) ? VMAX : a_hi;
    assign uy  = (b_lo > b_hi) ? VMAX : b_hi;
    assign mx  = is_neg(b_lo) ? b_lo : ({W{1'b0}} - b_lo);
    assign my  = is_neg(b_hi) ? b_hi : ({W{1'b0}} - b_hi);
    assign da  = a_hi - a_lo;
    assign dbw = b_hi - b_lo;

    // stage A
    logic [3:0]   r_a_op;
    logic         r_a_abot, r_a_bbot;
    logic [W-1:0] r_a_alo, r_a_ahi, r_a_blo, r_a_bhi;
    t_out         r_a_add, r_a_urem;
    logic [W-1:0] r_a_m, r_a_smin, r_a_smax, r_a_inc;
    logic         r_a_ha_lo, r_a_ha_hi, r_a_hb, r_a_cj, r_a_ile, r_a_big;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_op    <= i_item.opcode;
            r_a_abot  <= i_item.a_bottom;
            r_a_bbot  <= i_item.b_bottom;
            r_a_alo   <= a_lo;
            r_a_ahi   <= a_hi;
            r_a_blo   <= b_lo;
            r_a_bhi   <= b_hi;
            r_a_add   <= n_add;
            r_a_urem  <= mk({W{1'b0}}, (ux <= uy) ? ux : uy);
            r_a_m     <= slt(b_hi, b_lo) ? SMIN : (slt(mx, my) ? mx : my);
            r_a_smin  <= slt(a_hi, a_lo) ? SMIN : a_lo;
            r_a_smax  <= slt(a_hi, a_lo) ? SMAX : a_hi;
            r_a_ha_lo <= (b_lo - a_lo) <= da;
            r_a_ha_hi <= (b_hi - a_lo) <= da;
            r_a_hb    <= (a_lo - b_lo) <= dbw;
            r_a_cj    <= (b_hi - a_lo) <= (a_hi - b_lo);
            r_a_ile   <= (b_lo - a_lo) <= (b_hi - a_lo);
            r_a_inc   <= da;
            r_a_big   <= da >= SMAX;
        end
    end

    t_out         n_join, n_meet, n_srem;
    t_out         a_ival, b_ival;
    logic [1:0]   hf;
    logic [W-1:0] sr_lo, sr_hi;

    assign a_ival = '{r_bottom: r_a_abot, r_begin: r_a_alo, r_end: r_a_ahi};
    assign b_ival = '{r_bottom: r_a_bbot, r_begin: r_a_blo, r_end: r_a_bhi};
    assign hf     = {r_a_ha_lo, r_a_ha_hi};

    always_comb begin
        if (r_a_abot) begin
            n_join = b_ival;
        end else if (r_a_bbot) begin
            n_join = a_ival;
        end else begin
            case (hf)
                2'b00:   n_join = r_a_hb ? b_ival
                                  : (r_a_cj ? mk(r_a_alo, r_a_bhi) : mk(r_a_blo, r_a_ahi));
                2'b10:   n_join = mk(r_a_alo, r_a_bhi);
                2'b01:   n_join = mk(r_a_blo, r_a_ahi);
                default: n_join = r_a_ile ? a_ival : mk_top();
            endcase
        end
        if (r_a_abot || r_a_bbot) begin
            n_meet = mk_bot();
        end else begin
            case (hf)
                2'b00:   n_meet = r_a_hb ? a_ival : mk_bot();
                2'b10:   n_meet = mk(r_a_blo, r_a_ahi);
                2'b01:   n_meet = mk(r_a_alo, r_a_bhi);
                default: n_meet = r_a_ile ? b_ival : a_ival;
            endcase
        end
        sr_lo = {W{1'b0}};
        sr_hi = {W{1'b0}};
        if (is_neg(r_a_smin)) begin
            sr_lo = slt(r_a_smin, r_a_m) ? r_a_m : r_a_smin;
        end
        if (!is_neg(r_a_smax)) begin
            sr_hi = slt({W{1'b0}} - r_a_smax, r_a_m) ? ({W{1'b0}} - r_a_m) : r_a_smax;
        end
        n_srem = mk(sr_lo, sr_hi);
    end

    // stage B
    logic [3:0]   r_b_op;
    logic         r_b_anybot, r_b_big;
    logic [W-1:0] r_b_alo, r_b_ahi, r_b_inc;
    t_out         r_b_add, r_b_urem, r_b_srem, r_b_join, r_b_meet;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_op     <= r_a_op;
            r_b_anybot <= r_a_abot | r_a_bbot;
            r_b_big    <= r_a_big;
            r_b_alo    <= r_a_alo;
            r_b_ahi    <= r_a_ahi;
            r_b_inc    <= r_a_inc;
            r_b_add    <= r_a_add;
            r_b_urem   <= r_a_urem;
            r_b_srem   <= n_srem;
            r_b_join   <= n_join;
            r_b_meet   <= n_meet;
        end
    end

    t_out         n_widen;
    t_sc          n_sc;
    logic         fl, fh;
    logic [W-1:0] inc2;

    assign fl = r_b_join.r_begin != r_b_alo;
    assign fh = r_b_join.r_end != r_b_ahi;

    always_comb begin
        inc2 = (fl && fh) ? {1'b0, r_b_inc[W-1:1]} : r_b_inc;
        if (inc2 == {W{1'b0}}) inc2 = {{(W-1){1'b0}}, 1'b1};
        if (r_b_anybot) begin
            n_widen = r_b_join;
        end else if (r_b_big) begin
            n_widen = mk_top();
        end else begin
            n_widen = r_b_join;
            if (fl) n_widen.r_begin = r_b_join.r_begin - inc2;
            if (fh) n_widen.r_end = r_b_join.r_end + inc2;
        end
        n_sc.use_mul = 1'b0;
        n_sc.use_div = 1'b0;
        case (r_b_op)
            OP_ADD, OP_SUB: n_sc.res = r_b_add;
            OP_MUL: begin
                n_sc.res     = mk_bot();
                n_sc.use_mul = !r_b_anybot;
            end
            OP_UDIV: begin
                n_sc.res     = mk_bot();
                n_sc.use_div = !r_b_anybot;
            end
            OP_UREM:  n_sc.res = r_b_anybot ? mk_bot() : r_b_urem;
            OP_SREM:  n_sc.res = r_b_anybot ? mk_bot() : r_b_srem;
            OP_JOIN:  n_sc.res = r_b_join;
            OP_MEET:  n_sc.res = r_b_meet;
            OP_WIDEN: n_sc.res = n_widen;
            default:  n_sc.res = mk_top();
        endcase
        n_sc.res = clean(n_sc.res);
    end

    // stage C
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_sc <= n_sc;
        end
    end

endmodule

// File: design/wia_mul.sv
// Three-stage interval multiplier over the four sign-flipped operand pairs.
// Depends on wia_pkg; output is the tightest candidate, or top.
module wia_mul import wia_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  t_in  i_item,
    output t_out o_res
);

    logic [W-1:0] fa_lo [0:1];
    logic [W-1:0] fa_hi [0:1];
    logic [W-1:0] fb_lo [0:1];
    logic [W-1:0] fb_hi [0:1];

    assign fa_lo[0] = i_item.a_begin;
    assign fa_hi[0] = i_item.a_end;
    assign fa_lo[1] = {W{1'b0}} - i_item.a_end;
    assign fa_hi[1] = {W{1'b0}} - i_item.a_begin;
    assign fb_lo[0] = i_item.b_begin;
    assign fb_hi[0] = i_item.b_end;
    assign fb_lo[1] = {W{1'b0}} - i_item.b_end;
    assign fb_hi[1] = {W{1'b0}} - i_item.b_begin;

    logic [W-1:0]   r_xm [0:1];
    logic [W-1:0]   r_xn [0:1];
    logic [W-1:0]   r_ym [0:1];
    logic [W-1:0]   r_yn [0:1];
    logic [2*W-1:0] r_pe [0:3];
    logic [W-1:0]   r_pb [0:3];
    logic [W-1:0]   r_sz [0:3];
    logic [W-1:0]   r_rb [0:3];
    logic [W-1:0]   r_re [0:3];

    genvar j, i;
    generate
        for (j = 0; j < 2; j++) begin : g_flip
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_xm[j] <= (fa_lo[j] > fa_hi[j]) ? VMAX : fa_hi[j];
                    r_xn[j] <= (fa_lo[j] > fa_hi[j]) ? {W{1'b0}} : fa_lo[j];
                    r_ym[j] <= (fb_lo[j] > fb_hi[j]) ? VMAX : fb_hi[j];
                    r_yn[j] <= (fb_lo[j] > fb_hi[j]) ? {W{1'b0}} : fb_lo[j];
                end
            end
        end
        for (i = 0; i < 4; i++) begin : g_prod
            logic [W-1:0] pe, size;
            logic         ov;
            assign pe   = r_pe[i][W-1:0];
            assign ov   = |r_pe[i][2*W-1:W];
            assign size = pe - r_pb[i];
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pe[i] <= {{W{1'b0}}, r_xm[i % 2]} * {{W{1'b0}}, r_ym[i / 2]};
                    r_pb[i] <= W'(r_xn[i % 2] * r_yn[i / 2]);
                    r_sz[i] <= ov ? VMAX : size;
                    if (i == 1 || i == 2) begin
                        r_rb[i] <= {W{1'b0}} - pe;
                        r_re[i] <= {W{1'b0}} - r_pb[i];
                    end else begin
                        r_rb[i] <= r_pb[i];
                        r_re[i] <= pe;
                    end
                end
            end
        end
    endgenerate

    logic         pick01, pick23, pick_r;
    logic [W-1:0] sz_l, sz_r, rb_l, rb_r, re_l, re_r;

    always_comb begin
        pick01 = r_sz[1] < r_sz[0];
        pick23 = r_sz[3] < r_sz[2];
        sz_l   = pick01 ? r_sz[1] : r_sz[0];
        rb_l   = pick01 ? r_rb[1] : r_rb[0];
        re_l   = pick01 ? r_re[1] : r_re[0];
        sz_r   = pick23 ? r_sz[3] : r_sz[2];
        rb_r   = pick23 ? r_rb[3] : r_rb[2];
        re_r   = pick23 ? r_re[3] : r_re[2];
        pick_r = sz_r < sz_l;
        if ((pick_r ? sz_r : sz_l) == VMAX) begin
            o_res = mk_top();
        end else begin
            o_res = pick_r ? mk(rb_r, re_r) : mk(rb_l, re_l);
        end
    end

endmodule

// File: design/wia_div.sv
// Unsigned interval division: one setup stage, then W restoring stages,
// one quotient bit per stage for three lanes. Depends on wia_pkg.
module wia_div import wia_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_divin i_div,
    input  t_out   i_side,
    input  logic   i_use_div,
    output logic   o_valid,
    output t_out   o_res
);

    typedef enum logic [1:0] {
        SEL_SIDE,
        SEL_QUOT,
        SEL_MAXQ
    } t_sel;

    logic [W-1:0] db, de;
    logic         bz, wf_a, wf_b;
    t_sel         n_sel;
    t_out         n_res;

    always_comb begin
        bz   = (i_div.b_lo == {W{1'b0}}) && (i_div.b_hi == {W{1'b0}});
        db   = (i_div.b_lo == {W{1'b0}}) ? {{(W-1){1'b0}}, 1'b1} : i_div.b_lo;
        de   = (i_div.b_lo != {W{1'b0}} && i_div.b_hi == {W{1'b0}}) ? VMAX : i_div.b_hi;
        wf_a = i_div.a_lo > i_div.a_hi;
        wf_b = db > de;
        n_sel = SEL_SIDE;
        n_res = i_side;
        if (i_use_div) begin
            if (bz) begin
                n_res = mk_bot();
            end else if (!wf_a && !wf_b) begin
                n_sel = SEL_QUOT;
            end else if (!wf_a) begin
                n_res = mk({W{1'b0}}, i_div.a_hi);
            end else if (!wf_b) begin
                n_sel = SEL_MAXQ;
            end else begin
                n_res = mk_top();
            end
        end
    end

    logic         r_v   [0:W];
    t_sel         r_sel [0:W];
    t_out         r_res [0:W];
    logic [W-1:0] r_n   [0:W-1][0:2];
    logic [W-1:0] r_d   [0:W-1][0:2];
    logic [W-1:0] r_r   [0:W-1][0:2];
    logic [W-1:0] r_q   [0:W][0:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sel[0]  <= n_sel;
            r_res[0]  <= n_res;
            r_n[0][0] <= i_div.a_lo;
            r_d[0][0] <= de;
            r_n[0][1] <= i_div.a_hi;
            r_d[0][1] <= db;
            r_n[0][2] <= VMAX;
            r_d[0][2] <= db;
            for (int l = 0; l < 3; l++) begin
                r_r[0][l] <= {W{1'b0}};
                r_q[0][l] <= {W{1'b0}};
            end
        end
    end

    genvar k, ln;
    generate
        for (k = 0; k < W; k++) begin : g_stage
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k+1] <= 1'b0;
                end else if (i_en) begin
                    r_v[k+1] <= r_v[k];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_sel[k+1] <= r_sel[k];
                    r_res[k+1] <= r_res[k];
                end
            end
            for (ln = 0; ln < 3; ln++) begin : g_lane
                logic [W:0] rem_x, diff;
                logic       ge;
                assign rem_x = {r_r[k][ln], r_n[k][ln][W-1-k]};
                assign diff  = rem_x - {1'b0, r_d[k][ln]};
                assign ge    = rem_x >= {1'b0, r_d[k][ln]};
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_q[k+1][ln] <= {r_q[k][ln][W-2:0], ge};
                    end
                end
                if (k < W - 1) begin : g_carry
                    always_ff @(posedge i_clk) begin
                        if (i_en) begin
                            r_r[k+1][ln] <= ge ? diff[W-1:0] : rem_x[W-1:0];
                            r_n[k+1][ln] <= r_n[k][ln];
                            r_d[k+1][ln] <= r_d[k][ln];
                        end
                    end
                end
            end
        end
    endgenerate

    assign o_valid = r_v[W];

    always_comb begin
        case (r_sel[W])
            SEL_QUOT: o_res = mk(r_q[W][0], r_q[W][1]);
            SEL_MAXQ: o_res = mk({W{1'b0}}, r_q[W][2]);
            default:  o_res = r_res[W];
        endcase
    end

endmodule

// File: design/wrapped_interval_alu_core.sv
// Wrapped interval ALU core: input register, scalar and multiply units,
// divider pipeline, output register with skid. Depends on wia_pkg and subunits.
//
// Takes one item per cycle while o_stall is low and returns one result per
// item, in order. The restoring divider, one quotient bit per stage, sets
// the depth; add, lattice ops and multiply finish early and ride along. A skid
// register keeps input accepted after the output stalls until a result must
// wait in it; o_stall rises only when both output and skid hold items.
`include "wrapped_interval_alu_core_defines.svh"
module wrapped_interval_alu_core import wia_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    logic   pipe_en;
    logic   r_s1_v;
    t_in    r_s1;
    logic   r_fv  [0:2];
    t_divin r_fdi [0:2];
    t_sc    sc;
    t_out   mul_res, side, p_res;
    logic   p_v;
    logic   r_out_v, r_skid_v;
    t_out   r_out, r_skid;

    assign pipe_en = !r_skid_v;
    assign o_stall = r_skid_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            for (int s = 0; s < 3; s++) r_fv[s] <= 1'b0;
        end else if (pipe_en) begin
            r_s1_v  <= i_valid;
            r_fv[0] <= r_s1_v;
            r_fv[1] <= r_fv[0];
            r_fv[2] <= r_fv[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s1     <= i_data;
            r_fdi[0] <= '{a_lo: r_s1.a_begin, a_hi: r_s1.a_end,
                          b_lo: r_s1.b_begin, b_hi: r_s1.b_end};
            r_fdi[1] <= r_fdi[0];
            r_fdi[2] <= r_fdi[1];
        end
    end

    wia_scalar u_scalar (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_item (r_s1),
        .o_sc   (sc)
    );

    wia_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_item (r_s1),
        .o_res  (mul_res)
    );

    assign side = sc.use_mul ? mul_res : sc.res;

    wia_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (pipe_en),
        .i_valid   (r_fv[2]),
        .i_div     (r_fdi[2]),
        .i_side    (side),
        .i_use_div (sc.use_div),
        .o_valid   (p_v),
        .o_res     (p_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || !i_stall) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_out    <= r_skid;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v <= p_v;
                r_out   <= p_res;
            end
        end else if (p_v && pipe_en) begin
            r_skid   <= p_res;
            r_skid_v <= 1'b1;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

    `WIA_ASSERT_NOW(a_skid_needs_out, r_skid_v, r_out_v, "skid full with empty output")
    `WIA_ASSERT_NEXT(a_skid_holds, r_skid_v && i_stall, r_skid_v, "skid item lost")
    `WIA_ASSERT_NEXT(a_skid_drains, r_out_v && !i_stall && r_skid_v, !r_skid_v,
        "skid did not drain")
    `WIA_ASSERT_NOW(a_bottom_zero, o_valid && o_data.r_bottom,
        o_data.r_begin == '0 && o_data.r_end == '0, "bottom item with nonzero bounds")

endmodule

// File: tb/testbench.sv
// Self-checking testbench for wrapped_interval_alu_core: directed table, then random items.
// Unknown results are predicted by its interval functions; depends on wia_pkg and core RTL.
module testbench;
    import wia_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in  i_data = '0;
    logic o_stall;
    logic o_valid;
    t_out o_data;

    typedef struct packed {
        logic         bot;
        logic [W-1:0] lo;
        logic [W-1:0] hi;
    } t_iv;

    typedef struct {
        t_in  stim;
        logic known;
        t_out want;
    } t_row;

    t_out pending_results[$];
    int   fail_count = 0;
    int   src_idle = 0;
    int   rcv_stall = 0;
    t_row dir_rows[$];

    wrapped_interval_alu_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #50000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_iv iv(input logic [W-1:0] lo, input logic [W-1:0] hi);
        iv = '{1'b0, lo, hi};
    endfunction

    function automatic t_iv iv_bot();
        iv_bot = '{1'b1, '0, '0};
    endfunction

    function automatic logic s_less(input logic [W-1:0] x, input logic [W-1:0] y);
        s_less = (x ^ SMIN) < (y ^ SMIN);
    endfunction

    function automatic logic [W-1:0] u_top(input t_iv v);
        u_top = (v.lo > v.hi) ? VMAX : v.hi;
    endfunction

    function automatic logic [W-1:0] u_floor(input t_iv v);
        u_floor = (v.lo > v.hi) ? '0 : v.lo;
    endfunction

    function automatic logic [W-1:0] s_top(input t_iv v);
        s_top = s_less(v.hi, v.lo) ? SMAX : v.hi;
    endfunction

    function automatic logic [W-1:0] s_floor(input t_iv v);
        s_floor = s_less(v.hi, v.lo) ? SMIN : v.lo;
    endfunction

    function automatic logic rel_le(input t_iv v, input logic [W-1:0] x,
                                    input logic [W-1:0] y);
        logic [W-1:0] dx, dy;
        dx = x - v.lo;
        dy = y - v.lo;
        rel_le = dx <= dy;
    endfunction

    function automatic logic holds(input t_iv v, input logic [W-1:0] x);
        holds = !v.bot && rel_le(v, x, v.hi);
    endfunction

    function automatic t_iv sum_iv(input t_iv a, input t_iv b, input logic nuw,
                                   input logic nsw);
        logic [W-1:0] s, t, w1, w2, ws, ox;
        logic ov;
        if (a.bot || b.bot) return iv_bot();
        if (nuw && a.lo <= a.hi && b.lo <= b.hi) begin
            s = a.lo + b.lo;
            if (s < a.lo) return iv_bot();
            t = a.hi + b.hi;
            if (t < a.hi) t = VMAX;
            return iv(s, t);
        end
        if (nsw && !s_less(a.hi, a.lo) && !s_less(b.hi, b.lo)) begin
            s = a.lo + b.lo;
            ox = (a.lo ^ s) & (b.lo ^ s);
            ov = ox[W-1];
            if (ov && !a.lo[W-1]) return iv_bot();
            if (ov) s = SMIN;
            t = a.hi + b.hi;
            ox = (a.hi ^ t) & (b.hi ^ t);
            ov = ox[W-1];
            if (ov && a.hi[W-1]) return iv_bot();
            if (ov) t = SMAX;
            return iv(s, t);
        end
        w1 = a.hi - a.lo;
        w2 = b.hi - b.lo;
        ws = w1 + w2;
        if (ws < w1) return iv('0, VMAX);
        return iv(a.lo + b.lo, a.hi + b.hi);
    endfunction

    function automatic t_iv prod_iv(input t_iv a, input t_iv b);
        logic [W-1:0] rb, re, size, xm, ym, pe, pb;
        logic [2*W-1:0] full;
        t_iv l, r;
        rb = '0;
        re = '0;
        size = VMAX;
        for (int i = 0; i < 4; i++) begin
            l = (i & 1) ? iv(-a.hi, -a.lo) : a;
            r = (i & 2) ? iv(-b.hi, -b.lo) : b;
            xm = u_top(l);
            ym = u_top(r);
            full = xm * ym;
            pe = full[W-1:0];
            full = u_floor(l) * u_floor(r);
            pb = full[W-1:0];
            if (!(xm != 0 && ym > VMAX / xm) && (pe - pb) < size) begin
                size = pe - pb;
                if (((i ^ (i >> 1)) & 1) != 0) begin
                    rb = -pe;
                    re = -pb;
                end else begin
                    rb = pb;
                    re = pe;
                end
            end
        end
        if (size == VMAX) return iv('0, VMAX);
        return iv(rb, re);
    endfunction

    function automatic t_iv quot_iv(input t_iv a, input t_iv b);
        logic [W-1:0] db, de;
        db = b.lo;
        de = b.hi;
        if (db == 0 && de == 0) return iv_bot();
        if (db == 0) db = 1;
        else if (de == 0) de = VMAX;
        case ({a.lo > a.hi, db > de})
            2'b00: return iv(a.lo / de, a.hi / db);
            2'b01: return iv('0, a.hi);
            2'b10: return iv('0, VMAX / db);
            default: return iv('0, VMAX);
        endcase
    endfunction

    function automatic logic [W-1:0] neg_mag(input t_iv v);
        logic [W-1:0] x, y;
        if (s_less(v.hi, v.lo)) return SMIN;
        x = v.lo[W-1] ? v.lo : -v.lo;
        y = v.hi[W-1] ? v.hi : -v.hi;
        return s_less(x, y) ? x : y;
    endfunction

    function automatic t_iv srem_iv(input t_iv a, input t_iv b);
        logic [W-1:0] m, lo, hi;
        m = neg_mag(b);
        lo = s_floor(a);
        hi = s_top(a);
        if (lo[W-1]) begin
            if (s_less(lo, m)) lo = m;
        end else begin
            lo = '0;
        end
        if (!hi[W-1]) begin
            if (s_less(-hi, m)) hi = -m;
        end else begin
            hi = '0;
        end
        return iv(lo, hi);
    endfunction

    function automatic t_iv join_iv(input t_iv a, input t_iv b);
        logic [W-1:0] d1, d2;
        if (a.bot) return b;
        if (b.bot) return a;
        case ({holds(a, b.lo), holds(a, b.hi)})
            2'b00: begin
                if (holds(b, a.lo)) return b;
                d1 = b.hi - a.lo;
                d2 = a.hi - b.lo;
                return (d1 <= d2) ? iv(a.lo, b.hi) : iv(b.lo, a.hi);
            end
            2'b10: return iv(a.lo, b.hi);
            2'b01: return iv(b.lo, a.hi);
            default: return rel_le(a, b.lo, b.hi) ? a : iv('0, VMAX);
        endcase
    endfunction

    function automatic t_iv meet_iv(input t_iv a, input t_iv b);
        if (a.bot || b.bot) return iv_bot();
        case ({holds(a, b.lo), holds(a, b.hi)})
            2'b00: return holds(b, a.lo) ? a : iv_bot();
            2'b10: return iv(b.lo, a.hi);
            2'b01: return iv(a.lo, b.hi);
            default: return rel_le(a, b.lo, b.hi) ? b : a;
        endcase
    endfunction

    function automatic t_iv widen_iv(input t_iv a, input t_iv b);
        logic [W-1:0] inc;
        t_iv r;
        logic grow_lo, grow_hi;
        if (a.bot) return b;
        if (b.bot) return a;
        inc = a.hi - a.lo;
        if (inc >= SMAX) return iv('0, VMAX);
        r = join_iv(a, b);
        grow_lo = r.lo != a.lo;
        grow_hi = r.hi != a.hi;
        if (grow_lo && grow_hi) inc = inc >> 1;
        if (inc == 0) inc = 1;
        if (grow_lo) r.lo = r.lo - inc;
        if (grow_hi) r.hi = r.hi + inc;
        return r;
    endfunction

    function automatic t_out interval_result(input t_in d);
        t_iv a, b, r;
        logic any_bot;
        a = '{d.a_bottom, d.a_begin, d.a_end};
        b = '{d.b_bottom, d.b_begin, d.b_end};
        any_bot = a.bot || b.bot;
        case (d.opcode)
            OP_ADD:   r = sum_iv(a, b, d.no_unsigned_wrap, d.no_signed_wrap);
            OP_SUB:   r = any_bot ? iv_bot() : sum_iv(a, iv(-b.hi, -b.lo), 1'b0, 1'b0);
            OP_MUL:   r = any_bot ? iv_bot() : prod_iv(a, b);
            OP_UDIV:  r = any_bot ? iv_bot() : quot_iv(a, b);
            OP_UREM:  r = any_bot ? iv_bot()
                          : iv('0, (u_top(a) <= u_top(b)) ? u_top(a) : u_top(b));
            OP_SREM:  r = any_bot ? iv_bot() : srem_iv(a, b);
            OP_JOIN:  r = join_iv(a, b);
            OP_MEET:  r = meet_iv(a, b);
            OP_WIDEN: r = widen_iv(a, b);
            default:  r = iv('0, VMAX);
        endcase
        if (r.bot) return '{1'b1, '0, '0};
        return '{1'b0, r.lo, r.hi};
    endfunction

    task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                   input logic [W-1:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_out w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", o_data.r_begin, '0);
            end else begin
                w = pending_results.pop_front();
                if (o_data.r_bottom !== w.r_bottom)
                    report_mismatch("r_bottom", W'(o_data.r_bottom), W'(w.r_bottom));
                if (o_data.r_begin !== w.r_begin)
                    report_mismatch("r_begin", o_data.r_begin, w.r_begin);
                if (o_data.r_end !== w.r_end)
                    report_mismatch("r_end", o_data.r_end, w.r_end);
            end
        end
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < rcv_stall);
    end

    function automatic logic [W-1:0] edge_val();
        case ($urandom_range(7))
            0: return '0;
            1: return VMAX;
            2: return SMIN;
            3: return SMAX;
            4: return $urandom_range(16);
            5: return -$urandom_range(16);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in rand_item();
        t_in d;
        d.opcode = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 9))
                                             : 4'($urandom_range(8));
        d.a_bottom = ($urandom_range(9) == 0);
        d.b_bottom = ($urandom_range(9) == 0);
        d.a_begin = ($urandom_range(1)) ? edge_val() : $urandom;
        d.a_end = ($urandom_range(1)) ? d.a_begin + $urandom_range(1000) : $urandom;
        d.b_begin = ($urandom_range(1)) ? edge_val() : $urandom;
        d.b_end = ($urandom_range(1)) ? d.b_begin + $urandom_range(1000) : $urandom;
        d.no_unsigned_wrap = $urandom_range(1);
        d.no_signed_wrap = $urandom_range(1);
        return d;
    endfunction

    task automatic send_item(input t_in d, input logic known, input t_out want);
        while ($urandom_range(99) < src_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_results.push_back(known ? want : interval_result(d));
        @(negedge i_clk);
    endtask

    task automatic add_row(input t_op op, input logic ab, input logic [W-1:0] a0,
                           input logic [W-1:0] a1, input logic bb,
                           input logic [W-1:0] b0, input logic [W-1:0] b1,
                           input logic nuw, input logic nsw, input logic known,
                           input t_out want);
        t_row r;
        r.stim = '{op, ab, a0, a1, bb, b0, b1, nuw, nsw};
        r.known = known;
        r.want = want;
        dir_rows.push_back(r);
    endtask

    initial begin
        t_out bot_r, top_r;
        t_in d;
        int idle_src[4] = '{0, 76, 0, 11};
        int idle_rcv[4] = '{0, 0, 76, 11};
        bot_r = '{1'b1, '0, '0};
        top_r = '{1'b0, '0, VMAX};
        add_row(OP_ADD, 1, 5, 9, 0, 1, 2, 0, 0, 1, bot_r);
        add_row(OP_ADD, 0, VMAX, VMAX, 0, 1, 1, 1, 0, 1, bot_r);
        add_row(OP_ADD, 0, 1, VMAX, 0, 0, 5, 1, 0, 1, '{1'b0, 1, VMAX});
        add_row(OP_ADD, 0, SMAX, SMAX, 0, 1, 1, 0, 1, 1, bot_r);
        add_row(OP_ADD, 0, SMIN, SMIN + 3, 0, SMIN, SMIN + 1, 0, 1, 0, bot_r);
        add_row(OP_ADD, 0, 0, SMAX, 0, 0, 2, 0, 1, 0, bot_r);
        add_row(OP_ADD, 0, 0, VMAX - 1, 0, 0, 5, 0, 0, 1, top_r);
        add_row(OP_SUB, 0, 10, 20, 0, 1, 2, 0, 0, 1, '{1'b0, 8, 19});
        add_row(OP_SUB, 0, 10, 20, 1, 1, 2, 0, 0, 1, bot_r);
        add_row(OP_MUL, 0, 2, 3, 0, 4, 5, 0, 0, 1, '{1'b0, 8, 15});
        add_row(OP_MUL, 0, 0, VMAX, 0, 2, 3, 0, 0, 0, bot_r);
        add_row(OP_UDIV, 0, 10, 20, 0, 0, 0, 0, 0, 1, bot_r);
        add_row(OP_UDIV, 0, 10, 20, 0, 0, 5, 0, 0, 1, '{1'b0, 2, 20});
        add_row(OP_UDIV, 0, 10, 20, 0, 2, 0, 0, 0, 1, '{1'b0, 0, 10});
        add_row(OP_UDIV, 0, 20, 10, 0, 9, 3, 0, 0, 1, top_r);
        add_row(OP_UREM, 0, 0, 100, 0, 3, 7, 0, 0, 1, '{1'b0, 0, 7});
        add_row(OP_SREM, 0, SMIN, SMAX, 0, VMAX - 4, 5, 0, 0, 0, bot_r);
        add_row(OP_JOIN, 1, 1, 2, 0, 7, 9, 0, 0, 1, '{1'b0, 7, 9});
        add_row(OP_JOIN, 0, 10, 20, 0, 15, 30, 0, 0, 1, '{1'b0, 10, 30});
        add_row(OP_MEET, 0, 10, 20, 1, 15, 30, 0, 0, 1, bot_r);
        add_row(OP_MEET, 0, 10, 20, 0, 15, 30, 0, 0, 1, '{1'b0, 15, 20});
        add_row(OP_WIDEN, 0, 0, SMAX, 0, 5, 6, 0, 0, 1, top_r);
        add_row(OP_WIDEN, 0, 10, 20, 0, 15, 30, 0, 0, 0, bot_r);
        add_row(OP_WIDEN, 0, 1, 2, 1, 15, 30, 0, 0, 1, '{1'b0, 1, 2});
        add_row(t_op'(4'd12), 1, 3, 4, 1, 5, 6, 1, 1, 1, top_r);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (dir_rows[k]) send_item(dir_rows[k].stim, dir_rows[k].known,
                                        dir_rows[k].want);
        for (int ph = 0; ph < 8; ph++) begin
            src_idle = idle_src[ph % 4];
            rcv_stall = idle_rcv[ph % 4];
            repeat (190) begin
                d = rand_item();
                send_item(d, 1'b0, '0);
            end
            if (ph == 3) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
                while (pending_results.size() != 0) @(negedge i_clk);
            end
        end
        i_valid <= 1'b0;
        rcv_stall = 0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+design
design/wia_pkg.sv
design/wia_scalar.sv
design/wia_mul.sv
design/wia_div.sv
design/wrapped_interval_alu_core.sv
tb/testbench.sv
